### src/tlrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq_pkg
// Shared types and codes for the three-level ready queue: entry layout,
// command and status codes, row commands and row status flags.
// ----------------------------------------------------------------------------
package tlrq_pkg;

    // Field widths fixed by the transaction format
    localparam int ID_W    = 16;
    localparam int PRIO_W  = 4;
    localparam int KIND_W  = 3;
    localparam int CNT_W   = 5;
    localparam int LEVEL_W = 2;
    localparam int NUM_LEVELS = 3;

    // Priority routing thresholds
    localparam logic [PRIO_W-1:0] SYS_MAX_PRIO = 4'd1;
    localparam logic [PRIO_W-1:0] INTER_PRIO   = 4'd2;

    // Level codes
    localparam logic [LEVEL_W-1:0] LVL_SYS   = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_INTER = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_BACK  = 2'd2;

    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // One queued task
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [KIND_W-1:0] kind;
    } entry_t;

    // Command issued to a row of cells
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH,
        CMD_POP,
        CMD_MARK,
        CMD_COMPACT,
        CMD_CLEAR
    } row_cmd_t;

    // Status flags returned by a row
    typedef struct packed {
        logic empty;
        logic full;
        logic hit;
        logic settled;
    } row_stat_t;

endpackage

### src/tlrq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq_if
// Valid/ready channels of the ready queue: the command channel and the
// response channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface tlrq_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] task_id;
    logic [3:0]  prio;
    logic [2:0]  task_kind;
    logic [1:0]  level;

    modport source (output valid, output op, output task_id, output prio,
                    output task_kind, output level, input ready);
    modport sink   (input valid, input op, input task_id, input prio,
                    input task_kind, input level, output ready);
endinterface

interface tlrq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [3:0]  out_prio;
    logic [2:0]  out_kind;
    logic [4:0]  sys_count;
    logic [4:0]  inter_count;
    logic [4:0]  back_count;

    modport source (output valid, output status, output out_id, output out_prio,
                    output out_kind, output sys_count, output inter_count,
                    output back_count, input ready);
    modport sink   (input valid, input status, input out_id, input out_prio,
                    input out_kind, input sys_count, input inter_count,
                    input back_count, output ready);
endinterface

### src/tlrq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq_cell
// One slot of a queue row. Holds an entry and a kill flag, loads on push,
// takes its right neighbor on pop, and during a purge swaps with its
// neighbors so killed slots drift toward the tail.
// ----------------------------------------------------------------------------
module tlrq_cell
    import tlrq_pkg::*;
#(
    parameter int FILL_W = 5,
    parameter int IDX    = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  row_cmd_t          cmd,
    input  logic [FILL_W-1:0] fill,
    input  logic [ID_W-1:0]   id,
    input  entry_t            push_entry,
    input  entry_t            right_entry,
    input  logic              right_kill,
    input  logic              left_kill,
    output entry_t            entry,
    output logic              kill,
    output logic              hit
);

    entry_t entry_reg, entry_next;
    logic   kill_reg, kill_next;
    logic   live;
    logic   id_match;

    assign live     = fill > FILL_W'(IDX);
    assign id_match = entry_reg.id == id;
    assign hit      = live && id_match;

    // Next slot contents
    always_comb
    begin
        entry_next = entry_reg;
        kill_next  = kill_reg;
        case (cmd)
            CMD_PUSH:
            begin
                if (fill == FILL_W'(IDX))
                    entry_next = push_entry;
            end
            CMD_POP:
                entry_next = right_entry;
            CMD_MARK:
                kill_next = !live || id_match;
            CMD_COMPACT:
            begin
                // hole takes a live right neighbor; live slot under a hole gives
                if (kill_reg && !right_kill)
                begin
                    entry_next = right_entry;
                    kill_next  = 1'b0;
                end
                else if (!kill_reg && left_kill)
                begin
                    kill_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kill_reg <= 1'b0;
        else
            kill_reg <= kill_next;
    end

    assign entry = entry_reg;
    assign kill  = kill_reg;

endmodule

### src/tlrq_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq_row
// One FIFO level: a chain of cells with the head at cell 0 and a fill
// counter. A purge marks matching entries, then compacts one step per cycle
// while the fill counter walks down over killed slots at the tail.
// ----------------------------------------------------------------------------
module tlrq_row
    import tlrq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  row_cmd_t                     cmd,
    input  logic [ID_W-1:0]              id,
    input  entry_t                       push_entry,
    output entry_t                       head,
    output logic [$clog2(DEPTH+1)-1:0]   fill,
    output row_stat_t                    stat
);

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);

    entry_t             entries [DEPTH];
    logic [DEPTH-1:0]   kill_vec;
    logic [DEPTH-1:0]   hit_vec;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FILL_W-1:0]  fill_m1;
    logic [IDX_W-1:0]   tail_idx;
    logic               tail_kill;
    logic               gaps;

    // Chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t right_entry;
        logic   right_kill;
        logic   left_kill;

        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = '0;
            assign right_kill  = 1'b1;
        end
        else
        begin : g_mid
            assign right_entry = entries[i+1];
            assign right_kill  = kill_vec[i+1];
        end

        if (i == 0)
        begin : g_first
            assign left_kill = 1'b0;
        end
        else
        begin : g_rest
            assign left_kill = kill_vec[i-1];
        end

        tlrq_cell #(
            .FILL_W (FILL_W),
            .IDX    (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .fill        (fill_reg),
            .id          (id),
            .push_entry  (push_entry),
            .right_entry (right_entry),
            .right_kill  (right_kill),
            .left_kill   (left_kill),
            .entry       (entries[i]),
            .kill        (kill_vec[i]),
            .hit         (hit_vec[i])
        );
    end

    // Tail slot during a purge
    assign fill_m1   = fill_reg - 1'b1;
    assign tail_idx  = fill_m1[IDX_W-1:0];
    assign tail_kill = (fill_reg != '0) && kill_vec[tail_idx];

    // A hole still sits in front of a live slot
    assign gaps = |(kill_vec[DEPTH-2:0] & ~kill_vec[DEPTH-1:1]);

    // Fill counter
    always_comb
    begin
        fill_next = fill_reg;
        case (cmd)
            CMD_PUSH:
            begin
                if (fill_reg != FILL_W'(DEPTH))
                    fill_next = fill_reg + 1'b1;
            end
            CMD_POP:
            begin
                if (fill_reg != '0)
                    fill_next = fill_m1;
            end
            CMD_COMPACT:
            begin
                if (tail_kill)
                    fill_next = fill_m1;
            end
            CMD_CLEAR:
                fill_next = '0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    assign head         = entries[0];
    assign fill         = fill_reg;
    assign stat.empty   = fill_reg == '0;
    assign stat.full    = fill_reg == FILL_W'(DEPTH);
    assign stat.hit     = |hit_vec;
    assign stat.settled = !gaps && !tail_kill;

endmodule

### src/three_level_ready_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_ready_queue
// Three FIFO ready queues (system, interactive, background) of task entries.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command per transaction: enqueue (routed by priority,
//   0..1 system, 2 interactive, 3..15 background), dequeue from a level,
//   remove every entry with a task id, or clear all queues.
//   rsp returns exactly one transaction per command with the status, the
//   dequeued entry (zero otherwise) and the three occupancy counts after
//   the command.
//   Enqueue, dequeue and clear go through S_EXEC, which applies the command
//   to the rows of cells, then S_RESULT, which loads the response register;
//   a new command is taken in S_RESULT. Remove also passes through S_PURGE,
//   which compacts one step at a time until the killed slots reach the tail;
//   the neighbor-to-neighbor shift in the cell chain sets how long that takes.
//   The response register decouples the sides: a finished response waits
//   there while the next command is accepted; when rsp stalls with a
//   response held and another finished, cmd is held off until it drains.
//   Reset empties all three queues and drops any pending response.
// ----------------------------------------------------------------------------
module three_level_ready_queue
    import tlrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    tlrq_cmd_if.sink     cmd,
    tlrq_rsp_if.source   rsp
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PURGE,
        S_RESULT
    } state_t;

    state_t                state_reg;
    op_t                   op_reg;
    logic [ID_W-1:0]       id_reg;
    logic [PRIO_W-1:0]     prio_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [LEVEL_W-1:0]    level_reg;
    status_t               status_reg;
    entry_t                pend_reg;

    logic                  out_valid_reg;
    status_t               out_status_reg;
    entry_t                out_entry_reg;
    logic [CNT_W-1:0]      sys_cnt_reg;
    logic [CNT_W-1:0]      inter_cnt_reg;
    logic [CNT_W-1:0]      back_cnt_reg;

    row_cmd_t              row_cmd  [NUM_LEVELS];
    entry_t                row_head [NUM_LEVELS];
    logic [FILL_W-1:0]     row_fill [NUM_LEVELS];
    row_stat_t             row_stat [NUM_LEVELS];

    entry_t                push_entry;
    logic [LEVEL_W-1:0]    target;
    logic                  in_ready;
    logic                  in_fire;
    logic                  out_free;
    logic                  any_hit;
    logic                  all_settled;
    status_t               exec_status;
    entry_t                exec_entry;

    // Handshake
    assign out_free = !out_valid_reg || rsp.ready;
    assign in_ready = (state_reg == S_IDLE) || ((state_reg == S_RESULT) && out_free);
    assign in_fire  = cmd.valid && in_ready;
    assign cmd.ready = in_ready;

    // Enqueue routing by priority
    always_comb
    begin
        if (prio_reg <= SYS_MAX_PRIO)
            target = LVL_SYS;
        else if (prio_reg == INTER_PRIO)
            target = LVL_INTER;
        else
            target = LVL_BACK;
    end

    assign push_entry  = '{id: id_reg, prio: prio_reg, kind: kind_reg};
    assign any_hit     = row_stat[0].hit || row_stat[1].hit || row_stat[2].hit;
    assign all_settled = row_stat[0].settled && row_stat[1].settled
                         && row_stat[2].settled;

    // Row commands
    always_comb
    begin
        for (int r = 0; r < NUM_LEVELS; r++)
        begin
            row_cmd[r] = CMD_HOLD;
            if (state_reg == S_EXEC)
            begin
                case (op_reg)
                    OP_ENQ:
                    begin
                        if (target == LEVEL_W'(r) && !row_stat[r].full)
                            row_cmd[r] = CMD_PUSH;
                    end
                    OP_DEQ:
                    begin
                        if (level_reg == LEVEL_W'(r) && !row_stat[r].empty)
                            row_cmd[r] = CMD_POP;
                    end
                    OP_REMOVE:
                        row_cmd[r] = CMD_MARK;
                    default:
                        row_cmd[r] = CMD_CLEAR;
                endcase
            end
            else if (state_reg == S_PURGE)
            begin
                row_cmd[r] = CMD_COMPACT;
            end
        end
    end

    // Status and entry of the command being applied
    always_comb
    begin
        exec_status = ST_OK;
        exec_entry  = '0;
        case (op_reg)
            OP_ENQ:
            begin
                for (int r = 0; r < NUM_LEVELS; r++)
                begin
                    if (target == LEVEL_W'(r) && row_stat[r].full)
                        exec_status = ST_FULL;
                end
            end
            OP_DEQ:
            begin
                // level three has no queue and reads as empty
                exec_status = ST_EMPTY;
                for (int r = 0; r < NUM_LEVELS; r++)
                begin
                    if (level_reg == LEVEL_W'(r) && !row_stat[r].empty)
                    begin
                        exec_status = ST_OK;
                        exec_entry  = row_head[r];
                    end
                end
            end
            OP_REMOVE:
            begin
                if (!any_hit)
                    exec_status = ST_NOT_FOUND;
            end
            default: ;
        endcase
    end

    // Queue rows
    for (genvar r = 0; r < NUM_LEVELS; r++)
    begin : g_row
        tlrq_row #(
            .DEPTH (QUEUE_DEPTH)
        ) u_row (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (row_cmd[r]),
            .id         (id_reg),
            .push_entry (push_entry),
            .head       (row_head[r]),
            .fill       (row_fill[r]),
            .stat       (row_stat[r])
        );
    end

    // Sequencer and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drained response; a new one loaded in S_RESULT keeps it set
            if (out_valid_reg && rsp.ready && (state_reg != S_RESULT))
                out_valid_reg <= 1'b0;

            if (in_fire)
            begin
                op_reg    <= op_t'(cmd.op);
                id_reg    <= cmd.task_id;
                prio_reg  <= cmd.prio;
                kind_reg  <= cmd.task_kind;
                level_reg <= cmd.level;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    status_reg <= exec_status;
                    pend_reg   <= exec_entry;
                    if (op_reg == OP_REMOVE)
                        state_reg <= S_PURGE;
                    else
                        state_reg <= S_RESULT;
                end
                S_PURGE:
                begin
                    if (all_settled)
                        state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_entry_reg  <= pend_reg;
                        sys_cnt_reg    <= CNT_W'(row_fill[0]);
                        inter_cnt_reg  <= CNT_W'(row_fill[1]);
                        back_cnt_reg   <= CNT_W'(row_fill[2]);
                        state_reg      <= in_fire ? S_EXEC : S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.out_id      = out_entry_reg.id;
    assign rsp.out_prio    = out_entry_reg.prio;
    assign rsp.out_kind    = out_entry_reg.kind;
    assign rsp.sys_count   = sys_cnt_reg;
    assign rsp.inter_count = inter_cnt_reg;
    assign rsp.back_count  = back_cnt_reg;

endmodule
